>>> rtl/bpa_pkg.sv
package bpa_pkg;

  localparam int PAGE_BITS      = 10;
  localparam int CNT_W          = 11;
  localparam int PAGE_SPACE     = 1024;
  localparam int MAX_LVL        = 10;
  localparam int ORDERS_DEFAULT = 11;
  localparam int LVL_W          = 4;
  localparam int ORDER_W        = 4;
  localparam int ROW_W          = 32;
  localparam int ROW_BITS       = 5;
  localparam int ROWS           = 68;
  localparam int ROW_AW         = $clog2(ROWS);

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NOMEM    = 3'd1,
    ST_BAD      = 3'd2,
    ST_MISALIGN = 3'd3,
    ST_NOTFREE  = 3'd4,
    ST_ALREADY  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_RESERVE = 2'd2
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CHK, S_A_RD, S_A_FIX, S_AS_RD, S_AS_WR,
    S_F_RD, S_F_EV, S_M_RD, S_M_WR, S_R_RD, S_R_EV, S_RS_RD, S_RS_WR,
    S_REB_CLR, S_REB_TOP, S_REB_LOW, S_FIN
  } state_t;

  typedef enum logic [2:0] {
    L_HOLD, L_ZERO, L_INC, L_DEC, L_ORDER, L_FOUND, L_TOP
  } lvl_op_t;

  typedef enum logic [2:0] {
    I_HOLD, I_PAGE, I_UP, I_DOWN, I_SRCH, I_FOUND, I_FOUND_DN
  } idx_op_t;

  typedef enum logic [2:0] {
    WR_NONE, WR_CLR_CUR, WR_SET_CUR, WR_SET_BUD, WR_CLR_BUD, WR_CLR_LOW,
    WR_REB_TOP, WR_REB_LOW
  } wr_op_t;

  typedef struct packed {
    lvl_op_t lvl_op;
    idx_op_t idx_op;
    wr_op_t  wr_op;
    logic    req_load;
    logic    reb_clr;
    logic    rb_inc;
    logic    res_load;
    status_t res_code;
    logic    res_page_en;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       order_bad;
    logic       misalign;
    logic       beyond;
    logic       rsv_oor;
    logic       found;
    logic       hit;
    logic       cur;
    logic       bud;
    logic       lvl_at_top;
    logic       lvl_at_order;
    logic       lvl_zero;
    logic       reb_more;
    logic       reb_bit;
  } sts_t;

endpackage

>>> rtl/bpa_ram.sv
module bpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 68
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/bpa_datapath.sv
module bpa_datapath #(
  parameter int ORDERS = bpa_pkg::ORDERS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [bpa_pkg::CNT_W-1:0]      cfg_data,
  input  logic [1:0]                     operation,
  input  logic [bpa_pkg::ORDER_W-1:0]    order,
  input  logic [bpa_pkg::PAGE_BITS-1:0]  page,
  input  bpa_pkg::cmd_t                  cmd,
  output bpa_pkg::sts_t                  sts,
  output logic [2:0]                     status,
  output logic [bpa_pkg::PAGE_BITS-1:0]  page_out
);

  localparam int TOP_INT = (ORDERS - 1 > bpa_pkg::MAX_LVL) ? bpa_pkg::MAX_LVL : ORDERS - 1;
  localparam logic [bpa_pkg::LVL_W-1:0] TOP = bpa_pkg::LVL_W'(TOP_INT);
  localparam int AW = bpa_pkg::ROW_AW;
  localparam int RW = bpa_pkg::ROW_W;
  localparam int PB = bpa_pkg::PAGE_BITS;
  localparam int LW = bpa_pkg::LVL_W;

  function automatic logic [AW-1:0] row_base(input logic [LW-1:0] k);
    if (k <= LW'(5)) begin
      return AW'(7'd64 - (7'd64 >> k));
    end
    return AW'(7'd57 + 7'(k));
  endfunction

  function automatic logic [LW-1:0] lvl_of_row(input logic [AW-1:0] r);
    logic [LW-1:0] k;
    k = '0;
    for (int j = 0; j <= bpa_pkg::MAX_LVL; j++) begin
      if (r >= row_base(LW'(j))) begin
        k = LW'(j);
      end
    end
    return k;
  endfunction

  logic [bpa_pkg::CNT_W-1:0]   pcount;
  logic [1:0]                  op_q;
  logic [bpa_pkg::ORDER_W-1:0] order_q;
  logic [PB-1:0]               page_q;
  logic [LW-1:0]               lvl, lvl_next;
  logic [PB-1:0]               idx, idx_next;
  logic [4:0]                  rb;
  logic [bpa_pkg::ROWS-1:0]    row_nz;
  logic [AW-1:0]               addr_q, raddr, waddr;
  logic                        nz_q, we;
  logic [RW-1:0]               rdata, rdata_eff, wdata;
  bpa_pkg::status_t            res_status;
  logic [PB-1:0]               res_page;
  logic [2:0]                  status_q;
  logic [PB-1:0]               page_out_q;

  logic [AW-1:0]               lo, hi, found_row;
  logic                        found;
  logic [LW-1:0]               found_k;
  logic [4:0]                  lowb;
  logic [LW-1:0]               span;
  logic [5:0]                  row_cnt;
  logic [AW:0]                 row_end;
  logic [4:0]                  w_bits;
  logic                        hit;
  logic [15:0]                 size;
  logic [bpa_pkg::CNT_W-1:0]   nblk, remain, reb_shift;
  logic [PB-1:0]               reb_idx;
  logic [RW-1:0]               reb_mask;
  logic [4:0]                  boff, soff;

  bpa_ram #(.WIDTH(RW), .DEPTH(bpa_pkg::ROWS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign raddr     = row_base(lvl) + AW'(idx >> bpa_pkg::ROW_BITS);
  assign rdata_eff = nz_q ? rdata : '0;

  // lowest free block among orders order_q .. TOP
  always_comb begin
    lo        = row_base(order_q);
    hi        = row_base(TOP + LW'(1));
    found     = 1'b0;
    found_row = '0;
    for (int r = bpa_pkg::ROWS - 1; r >= 0; r--) begin
      if (row_nz[r] && (AW'(r) >= lo) && (AW'(r) < hi) && (order_q <= TOP)) begin
        found     = 1'b1;
        found_row = AW'(r);
      end
    end
    found_k = lvl_of_row(found_row);
  end

  always_comb begin
    lowb = '0;
    for (int b = RW - 1; b >= 0; b--) begin
      if (rdata_eff[b]) begin
        lowb = 5'(b);
      end
    end
  end

  // overlap of the block being freed with free blocks at level lvl
  always_comb begin
    span    = (lvl < order_q) ? order_q - lvl : '0;
    row_cnt = (span >= LW'(5)) ? 6'(6'd1 << (span - LW'(5))) : 6'd1;
    row_end = {1'b0, addr_q} + (AW + 1)'(row_cnt);
    w_bits  = (span >= LW'(5)) ? 5'd0 : 5'(5'd1 << span);
    hit     = 1'b0;
    if (span >= LW'(5)) begin
      for (int r = 0; r < bpa_pkg::ROWS; r++) begin
        if (row_nz[r] && (AW'(r) >= addr_q) && ((AW + 1)'(r) < row_end)) begin
          hit = 1'b1;
        end
      end
    end else begin
      for (int b = 0; b < RW; b++) begin
        if (rdata_eff[b] && (6'(b) >= {1'b0, idx[4:0]}) &&
            (6'(b) < ({1'b0, idx[4:0]} + {1'b0, w_bits}))) begin
          hit = 1'b1;
        end
      end
    end
  end

  always_comb begin
    unique case (cmd.lvl_op)
      bpa_pkg::L_HOLD:  lvl_next = lvl;
      bpa_pkg::L_ZERO:  lvl_next = '0;
      bpa_pkg::L_INC:   lvl_next = lvl + LW'(1);
      bpa_pkg::L_DEC:   lvl_next = lvl - LW'(1);
      bpa_pkg::L_ORDER: lvl_next = order_q;
      bpa_pkg::L_FOUND: lvl_next = found_k;
      bpa_pkg::L_TOP:   lvl_next = TOP;
      default:          lvl_next = lvl;
    endcase
  end

  always_comb begin
    boff = 5'(addr_q - row_base(lvl));
    soff = 5'(found_row - row_base(found_k));
    unique case (cmd.idx_op)
      bpa_pkg::I_HOLD:     idx_next = idx;
      bpa_pkg::I_PAGE:     idx_next = page_q >> lvl_next;
      bpa_pkg::I_UP:       idx_next = idx >> 1;
      bpa_pkg::I_DOWN:     idx_next = idx << 1;
      bpa_pkg::I_SRCH:     idx_next = {soff, 5'd0};
      bpa_pkg::I_FOUND:    idx_next = {boff, lowb};
      bpa_pkg::I_FOUND_DN: idx_next = {boff[3:0], lowb, 1'b0};
      default:             idx_next = idx;
    endcase
  end

  always_comb begin
    nblk      = pcount >> TOP;
    remain    = nblk - {1'b0, rb, 5'd0};
    reb_mask  = (remain >= bpa_pkg::CNT_W'(RW)) ? '1 : ((RW'(1) << remain[4:0]) - RW'(1));
    reb_shift = pcount >> lvl;
    reb_idx   = {reb_shift[PB-1:1], 1'b0};
  end

  always_comb begin
    we    = 1'b1;
    waddr = addr_q;
    wdata = rdata_eff;
    unique case (cmd.wr_op)
      bpa_pkg::WR_NONE:    we = 1'b0;
      bpa_pkg::WR_CLR_CUR: wdata = rdata_eff & ~(RW'(1) << idx[4:0]);
      bpa_pkg::WR_SET_CUR: wdata = rdata_eff | (RW'(1) << idx[4:0]);
      bpa_pkg::WR_SET_BUD: wdata = rdata_eff | (RW'(1) << (idx[4:0] ^ 5'd1));
      bpa_pkg::WR_CLR_BUD: wdata = rdata_eff & ~(RW'(1) << (idx[4:0] ^ 5'd1));
      bpa_pkg::WR_CLR_LOW: wdata = rdata_eff & ~(RW'(1) << lowb);
      bpa_pkg::WR_REB_TOP: begin
        waddr = row_base(TOP) + AW'(rb);
        wdata = reb_mask;
      end
      bpa_pkg::WR_REB_LOW: begin
        waddr = row_base(lvl) + AW'(reb_idx >> bpa_pkg::ROW_BITS);
        wdata = RW'(1) << reb_idx[4:0];
      end
      default: we = 1'b0;
    endcase
  end

  always_comb begin
    size             = 16'd1 << order_q;
    sts.op           = op_q;
    sts.order_bad    = {1'b0, order_q} >= 5'(ORDERS);
    sts.misalign     = ({6'd0, page_q} & (size - 16'd1)) != 16'd0;
    sts.beyond       = ({7'd0, page_q} + {1'b0, size}) > {6'd0, pcount};
    sts.rsv_oor      = {1'b0, page_q} >= pcount;
    sts.found        = found;
    sts.hit          = hit;
    sts.cur          = rdata_eff[idx[4:0]];
    sts.bud          = rdata_eff[idx[4:0] ^ 5'd1];
    sts.lvl_at_top   = lvl == TOP;
    sts.lvl_at_order = lvl == order_q;
    sts.lvl_zero     = lvl == '0;
    sts.reb_more     = {1'b0, rb, 5'd0} < nblk;
    sts.reb_bit      = pcount[lvl];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pcount <= '0;
      row_nz <= '0;
      lvl    <= '0;
      rb     <= '0;
    end else begin
      if (cfg_we) begin
        pcount <= (cfg_data > bpa_pkg::CNT_W'(bpa_pkg::PAGE_SPACE)) ?
                  bpa_pkg::CNT_W'(bpa_pkg::PAGE_SPACE) : cfg_data;
      end
      if (cmd.reb_clr) begin
        row_nz <= '0;
      end else if (we) begin
        row_nz[waddr] <= |wdata;
      end
      lvl <= lvl_next;
      if (cmd.reb_clr) begin
        rb <= '0;
      end else if (cmd.rb_inc) begin
        rb <= rb + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx    <= idx_next;
    addr_q <= raddr;
    nz_q   <= row_nz[raddr];
    if (cmd.req_load) begin
      op_q    <= operation;
      order_q <= order;
      page_q  <= page;
    end
    if (cmd.res_load) begin
      res_status <= cmd.res_code;
      res_page   <= cmd.res_page_en ? (idx_next << lvl_next) : '0;
    end
    if (cmd.out_load) begin
      status_q   <= res_status;
      page_out_q <= res_page;
    end
  end

  assign status   = status_q;
  assign page_out = page_out_q;

  a_low_row_nonzero: assert property (@(posedge clk) disable iff (rst)
    (cmd.wr_op == bpa_pkg::WR_CLR_LOW) |-> (rdata_eff != '0))
    else $error("allocate picked a row with no free block");

  a_lvl_range: assert property (@(posedge clk) disable iff (rst)
    lvl <= TOP)
    else $error("level beyond top order");

endmodule

>>> rtl/bpa_ctrl.sv
module bpa_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  bpa_pkg::sts_t  sts,
  output bpa_pkg::cmd_t  cmd
);

  bpa_pkg::state_t state, state_next;
  logic            out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == bpa_pkg::S_IDLE) && !cfg_we;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bpa_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next      = state;
    cmd.lvl_op      = bpa_pkg::L_HOLD;
    cmd.idx_op      = bpa_pkg::I_HOLD;
    cmd.wr_op       = bpa_pkg::WR_NONE;
    cmd.req_load    = 1'b0;
    cmd.reb_clr     = 1'b0;
    cmd.rb_inc      = 1'b0;
    cmd.res_load    = 1'b0;
    cmd.res_code    = bpa_pkg::ST_OK;
    cmd.res_page_en = 1'b0;
    cmd.out_load    = 1'b0;
    unique case (state)
      bpa_pkg::S_IDLE: begin
        if (cfg_we) begin
          state_next = bpa_pkg::S_REB_CLR;
        end else if (in_valid) begin
          cmd.req_load = 1'b1;
          state_next   = bpa_pkg::S_CHK;
        end
      end
      bpa_pkg::S_CHK: begin
        state_next   = bpa_pkg::S_FIN;
        cmd.res_load = 1'b1;
        cmd.res_code = bpa_pkg::ST_BAD;
        unique case (sts.op)
          bpa_pkg::OP_ALLOC: begin
            if (sts.order_bad) begin
              cmd.res_code = bpa_pkg::ST_BAD;
            end else if (!sts.found) begin
              cmd.res_code = bpa_pkg::ST_NOMEM;
            end else begin
              cmd.res_load = 1'b0;
              cmd.lvl_op   = bpa_pkg::L_FOUND;
              cmd.idx_op   = bpa_pkg::I_SRCH;
              state_next   = bpa_pkg::S_A_RD;
            end
          end
          bpa_pkg::OP_FREE: begin
            if (sts.order_bad) begin
              cmd.res_code = bpa_pkg::ST_BAD;
            end else if (sts.misalign) begin
              cmd.res_code = bpa_pkg::ST_MISALIGN;
            end else if (sts.beyond) begin
              cmd.res_code = bpa_pkg::ST_BAD;
            end else begin
              cmd.res_load = 1'b0;
              cmd.lvl_op   = bpa_pkg::L_ZERO;
              cmd.idx_op   = bpa_pkg::I_PAGE;
              state_next   = bpa_pkg::S_F_RD;
            end
          end
          bpa_pkg::OP_RESERVE: begin
            if (!sts.rsv_oor) begin
              cmd.res_load = 1'b0;
              cmd.lvl_op   = bpa_pkg::L_ZERO;
              cmd.idx_op   = bpa_pkg::I_PAGE;
              state_next   = bpa_pkg::S_R_RD;
            end
          end
          default: cmd.res_code = bpa_pkg::ST_BAD;
        endcase
      end
      bpa_pkg::S_A_RD: state_next = bpa_pkg::S_A_FIX;
      bpa_pkg::S_A_FIX: begin
        cmd.wr_op = bpa_pkg::WR_CLR_LOW;
        if (sts.lvl_at_order) begin
          cmd.idx_op      = bpa_pkg::I_FOUND;
          cmd.res_load    = 1'b1;
          cmd.res_page_en = 1'b1;
          state_next      = bpa_pkg::S_FIN;
        end else begin
          cmd.idx_op = bpa_pkg::I_FOUND_DN;
          cmd.lvl_op = bpa_pkg::L_DEC;
          state_next = bpa_pkg::S_AS_RD;
        end
      end
      bpa_pkg::S_AS_RD: state_next = bpa_pkg::S_AS_WR;
      bpa_pkg::S_AS_WR: begin
        cmd.wr_op = bpa_pkg::WR_SET_BUD;
        if (sts.lvl_at_order) begin
          cmd.res_load    = 1'b1;
          cmd.res_page_en = 1'b1;
          state_next      = bpa_pkg::S_FIN;
        end else begin
          cmd.lvl_op = bpa_pkg::L_DEC;
          cmd.idx_op = bpa_pkg::I_DOWN;
          state_next = bpa_pkg::S_AS_RD;
        end
      end
      bpa_pkg::S_F_RD: state_next = bpa_pkg::S_F_EV;
      bpa_pkg::S_F_EV: begin
        if (sts.hit) begin
          cmd.res_load = 1'b1;
          cmd.res_code = bpa_pkg::ST_ALREADY;
          state_next   = bpa_pkg::S_FIN;
        end else if (sts.lvl_at_top) begin
          cmd.lvl_op = bpa_pkg::L_ORDER;
          cmd.idx_op = bpa_pkg::I_PAGE;
          state_next = bpa_pkg::S_M_RD;
        end else begin
          cmd.lvl_op = bpa_pkg::L_INC;
          cmd.idx_op = bpa_pkg::I_PAGE;
          state_next = bpa_pkg::S_F_RD;
        end
      end
      bpa_pkg::S_M_RD: state_next = bpa_pkg::S_M_WR;
      bpa_pkg::S_M_WR: begin
        if (!sts.lvl_at_top && sts.bud) begin
          cmd.wr_op  = bpa_pkg::WR_CLR_BUD;
          cmd.lvl_op = bpa_pkg::L_INC;
          cmd.idx_op = bpa_pkg::I_UP;
          state_next = bpa_pkg::S_M_RD;
        end else begin
          cmd.wr_op    = bpa_pkg::WR_SET_CUR;
          cmd.res_load = 1'b1;
          state_next   = bpa_pkg::S_FIN;
        end
      end
      bpa_pkg::S_R_RD: state_next = bpa_pkg::S_R_EV;
      bpa_pkg::S_R_EV: begin
        if (sts.cur) begin
          cmd.wr_op = bpa_pkg::WR_CLR_CUR;
          if (sts.lvl_zero) begin
            cmd.res_load = 1'b1;
            state_next   = bpa_pkg::S_FIN;
          end else begin
            cmd.lvl_op = bpa_pkg::L_DEC;
            cmd.idx_op = bpa_pkg::I_PAGE;
            state_next = bpa_pkg::S_RS_RD;
          end
        end else if (sts.lvl_at_top) begin
          cmd.res_load = 1'b1;
          cmd.res_code = bpa_pkg::ST_NOTFREE;
          state_next   = bpa_pkg::S_FIN;
        end else begin
          cmd.lvl_op = bpa_pkg::L_INC;
          cmd.idx_op = bpa_pkg::I_PAGE;
          state_next = bpa_pkg::S_R_RD;
        end
      end
      bpa_pkg::S_RS_RD: state_next = bpa_pkg::S_RS_WR;
      bpa_pkg::S_RS_WR: begin
        cmd.wr_op = bpa_pkg::WR_SET_BUD;
        if (sts.lvl_zero) begin
          cmd.res_load = 1'b1;
          state_next   = bpa_pkg::S_FIN;
        end else begin
          cmd.lvl_op = bpa_pkg::L_DEC;
          cmd.idx_op = bpa_pkg::I_PAGE;
          state_next = bpa_pkg::S_RS_RD;
        end
      end
      bpa_pkg::S_REB_CLR: begin
        cmd.reb_clr = 1'b1;
        cmd.lvl_op  = bpa_pkg::L_TOP;
        state_next  = bpa_pkg::S_REB_TOP;
      end
      bpa_pkg::S_REB_TOP: begin
        if (sts.reb_more) begin
          cmd.wr_op  = bpa_pkg::WR_REB_TOP;
          cmd.rb_inc = 1'b1;
        end else if (sts.lvl_zero) begin
          state_next = bpa_pkg::S_IDLE;
        end else begin
          cmd.lvl_op = bpa_pkg::L_DEC;
          state_next = bpa_pkg::S_REB_LOW;
        end
      end
      bpa_pkg::S_REB_LOW: begin
        if (sts.reb_bit) begin
          cmd.wr_op = bpa_pkg::WR_REB_LOW;
        end
        if (sts.lvl_zero) begin
          state_next = bpa_pkg::S_IDLE;
        end else begin
          cmd.lvl_op = bpa_pkg::L_DEC;
        end
      end
      bpa_pkg::S_FIN: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = bpa_pkg::S_IDLE;
        end
      end
      default: state_next = bpa_pkg::S_IDLE;
    endcase
  end

  a_out_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> out_free)
    else $error("result loaded over an untaken beat");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item taken while one is in flight");

endmodule

>>> rtl/buddy_page_allocator_unit.sv
// Channel   Handshake            Beat payload
// in        in_valid / in_ready  operation, order, page
// out       out_valid/ out_ready status, page_out
// cfg       cfg_we (no wait)     cfg_data = page_count
//
// One item at a time. Each level visited is read from the map RAM and, where
// it changes, written back; accept, decode and hand-over are steps of their
// own. Allocate splits down from the lowest free order found; free checks each
// level up to the top order for overlap, then merges with free buddies; reserve
// searches up for the free block that holds the page, then splits down to level
// 0. A request rejected at decode goes straight to hand-over.
// Writing page_count in the idle state rebuilds the map, the top-order rows
// first, then the lower levels; no item is taken meanwhile.
// Reset empties the map (no page free) and sets page_count to 0.
// A stalled result beat holds in the output register; the next item is
// taken, worked on and held back only at its hand-over.
module buddy_page_allocator_unit #(
  parameter int ORDERS = bpa_pkg::ORDERS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bpa_pkg::CNT_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    operation,
  input  logic [bpa_pkg::ORDER_W-1:0]   order,
  input  logic [bpa_pkg::PAGE_BITS-1:0] page,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    status,
  output logic [bpa_pkg::PAGE_BITS-1:0] page_out
);

  // command and status between sequencer and map datapath
  bpa_pkg::cmd_t cmd;
  bpa_pkg::sts_t sts;

  // sequencer: decode, walk the levels, drive the result beat
  bpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: free map RAM with per-row occupancy, level/index registers,
  // request, result and output registers
  bpa_datapath #(.ORDERS(ORDERS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .operation (operation),
    .order     (order),
    .page      (page),
    .cmd       (cmd),
    .sts       (sts),
    .status    (status),
    .page_out  (page_out)
  );

endmodule
